### rtl/adcseq_pkg.sv
// Package for the three-converter SPI readout sequencer.
// Holds the word types, command and phase codes, and fixed constants.
// No dependencies; every other file in rtl/ imports it.
package adcseq_pkg;

    // Reset value of the oversampling command register.
    localparam logic [7:0] OSR_RESET     = 8'h30;
    // Masks that drop the status bits from the leading byte of each reading.
    localparam logic [7:0] PRESS_HI_MASK = 8'h1F;
    localparam logic [7:0] AUX_HI_MASK   = 8'h7F;

    localparam int unsigned SAMPLE_BYTES = 8;
    localparam int unsigned CNT_W        = $clog2(SAMPLE_BYTES);

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_FETCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_TEMP  = 2'd2,
        PH_BATT  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] cmd;
        logic       busy_level;
        logic       miso_level;
        logic       byte_valid;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic        data_ready;
        logic        fetch_status;
        logic [23:0] pressure;
        logic [11:0] temperature;
        logic [9:0]  battery;
        logic        cs_pressure_n;
        logic        cs_temp_n;
        logic        cs_batt_n;
        logic        send_valid;
        logic [7:0]  send_byte;
    } t_out_word;

endpackage

### rtl/adcseq_ifs.sv
// Valid/ready channel interfaces for the readout sequencer: poll input,
// result output and the configuration write channel.
// Depends on adcseq_pkg for the word types.
interface adcseq_in_if;
    import adcseq_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adcseq_out_if;
    import adcseq_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adcseq_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/three_adc_spi_readout_sequencer.sv
// Top level of the readout sequencer for the pressure, temperature and
// battery converters on one SPI port. Uses adcseq_pkg and the channel
// interfaces in adcseq_ifs.sv.
//
//  Channel   Direction  Word                         Handshake
//  i_in      in         cmd, pins, received byte     valid/ready, sink
//  o_out     out        fetch data, selects, send    valid/ready, source
//  i_cfg     in         oversampling command byte    valid/ready, sink
//
// A word is taken into an input register and its result then lands in
// the output register behind it, so a new word can be accepted every cycle
// while the output is not stalled. The only loop is the sequencer state,
// which is updated in the same single pass that forms the result.
// Reset (synchronous, active low) deselects all converters, clears the
// phase, byte count and new-data flag, and loads 0x30 as command byte.
// When the output is stalled the input register holds and i_in.ready
// drops only once both registers are full. The configuration channel is
// always ready.
module three_adc_spi_readout_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    adcseq_in_if.sink            i_in,
    adcseq_out_if.source         o_out,
    adcseq_cfg_if.sink           i_cfg
);
    import adcseq_pkg::*;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Sequencer state.
    t_phase     r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic       r_fresh, n_fresh;
    logic [2:0] r_sel, n_sel;
    logic [7:0] r_osr;
    logic [7:0] r_sample [SAMPLE_BYTES];

    t_out_word  n_out;
    logic       w_out_free;
    logic       w_process;
    logic       w_store;
    logic [CNT_W:0] w_next_cnt;
    logic [7:0] w_s0, w_s4, w_s6;

    // The output register can take a result when empty or being drained.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_process   = r_in_valid && w_out_free;
    assign i_in.ready  = !r_in_valid || w_out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_process) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osr <= OSR_RESET;
        end else if (i_cfg.valid) begin
            r_osr <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_count <= '0;
            r_fresh <= 1'b0;
            r_sel   <= 3'b111;
        end else if (w_process) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_fresh <= n_fresh;
            r_sel   <= n_sel;
        end
    end

    // Sample bytes are written at the current byte count; no reset needed,
    // since a fetch only reads them after a full set has been gathered.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_sample[r_count] <= r_in.rx_byte;
        end
    end

    assign w_s0 = r_sample[0] & PRESS_HI_MASK;
    assign w_s4 = r_sample[4] & AUX_HI_MASK;
    assign w_s6 = r_sample[6] & AUX_HI_MASK;
    assign w_next_cnt = {1'b0, r_count} + 1'b1;
    assign w_store = w_process && (t_cmd'(r_in.cmd) == CMD_POLL) && r_in.byte_valid;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_fresh = r_fresh;
        n_sel   = r_sel;
        n_out   = '0;

        case (t_cmd'(r_in.cmd))
            CMD_POLL: begin
                // End of conversion starts the next transfer.
                case (r_phase)
                    PH_PRESS: begin
                        if (!r_in.busy_level) begin
                            n_sel[0]        = 1'b0;
                            n_out.send_valid = 1'b1;
                            n_out.send_byte  = r_osr;
                            n_phase         = PH_NONE;
                        end
                    end
                    PH_TEMP, PH_BATT: begin
                        if (r_in.miso_level) begin
                            n_out.send_valid = 1'b1;
                            n_out.send_byte  = 8'h00;
                            n_phase         = PH_NONE;
                        end
                    end
                    default: begin
                    end
                endcase
                // A finished byte either closes a converter's group or
                // continues the transfer with a zero byte, which wins over
                // any send chosen above.
                if (r_in.byte_valid) begin
                    n_fresh = 1'b0;
                    if (w_next_cnt == (CNT_W+1)'(4)) begin
                        n_sel[0] = 1'b1;
                        n_sel[1] = 1'b0;
                        n_phase  = PH_TEMP;
                        n_count  = CNT_W'(4);
                    end else if (w_next_cnt == (CNT_W+1)'(6)) begin
                        n_sel[1] = 1'b1;
                        n_sel[2] = 1'b0;
                        n_phase  = PH_BATT;
                        n_count  = CNT_W'(6);
                    end else if (w_next_cnt == (CNT_W+1)'(SAMPLE_BYTES)) begin
                        n_sel[2] = 1'b1;
                        n_count  = '0;
                        n_fresh  = 1'b1;
                        n_phase  = PH_PRESS;
                    end else begin
                        n_count          = w_next_cnt[CNT_W-1:0];
                        n_out.send_valid = 1'b1;
                        n_out.send_byte  = 8'h00;
                    end
                end
            end
            CMD_START: begin
                n_phase = PH_PRESS;
            end
            CMD_STOP: begin
                n_sel   = 3'b111;
                n_count = '0;
                n_fresh = 1'b0;
                n_phase = PH_NONE;
            end
            CMD_FETCH: begin
                if (!r_fresh) begin
                    n_out.fetch_status = 1'b1;
                end else begin
                    n_out.pressure    = {w_s0[4:0], r_sample[1], r_sample[2],
                                         r_sample[3][7:5]};
                    n_out.temperature = {w_s4[6:0], r_sample[5][7:3]};
                    n_out.battery     = {w_s6[6:0], r_sample[7][7:5]};
                    n_fresh           = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_out.data_ready    = n_fresh;
        n_out.cs_pressure_n = n_sel[0];
        n_out.cs_temp_n     = n_sel[1];
        n_out.cs_batt_n     = n_sel[2];
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for three_adc_spi_readout_sequencer.
// Depends on adcseq_pkg and the channel interfaces in adcseq_ifs.sv. A scoreboard
// class predicts every result word and checks what the block produces.
import adcseq_pkg::*;

class readout_scoreboard;
    logic [7:0]  osr_byte;
    t_phase      wait_ph;
    logic [2:0]  byte_cnt;
    logic [7:0]  sample_mem [SAMPLE_BYTES];
    bit          fresh;
    logic [2:0]  selects;
    t_out_word   pending_q [$];
    int          errors;

    function new();
        osr_byte = OSR_RESET;
        wait_ph  = PH_NONE;
        byte_cnt = '0;
        fresh    = 1'b0;
        selects  = 3'b111;
        errors   = 0;
    endfunction

    function void write_command(logic [7:0] value);
        osr_byte = value;
    endfunction

    // Advance the predicted sequencer by one accepted input word.
    function void note_input(t_in_word w);
        t_out_word r;
        logic [3:0] n;
        r = '0;
        case (t_cmd'(w.cmd))
            CMD_POLL: begin
                if (wait_ph == PH_PRESS) begin
                    if (!w.busy_level) begin
                        selects[0]  = 1'b0;
                        r.send_valid = 1'b1;
                        r.send_byte  = osr_byte;
                        wait_ph      = PH_NONE;
                    end
                end else if (wait_ph == PH_TEMP || wait_ph == PH_BATT) begin
                    if (w.miso_level) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = 8'h00;
                        wait_ph      = PH_NONE;
                    end
                end
                if (w.byte_valid) begin
                    fresh = 1'b0;
                    sample_mem[byte_cnt] = w.rx_byte;
                    n = {1'b0, byte_cnt} + 4'd1;
                    if (n == 4'd4) begin
                        selects  = (selects | 3'b001) & 3'b101;
                        wait_ph  = PH_TEMP;
                        byte_cnt = 3'd4;
                    end else if (n == 4'd6) begin
                        selects  = (selects | 3'b010) & 3'b011;
                        wait_ph  = PH_BATT;
                        byte_cnt = 3'd6;
                    end else if (n == 4'(SAMPLE_BYTES)) begin
                        selects  = selects | 3'b100;
                        byte_cnt = 3'd0;
                        fresh    = 1'b1;
                        wait_ph  = PH_PRESS;
                    end else begin
                        byte_cnt     = n[2:0];
                        r.send_valid = 1'b1;
                        r.send_byte  = 8'h00;
                    end
                end
            end
            CMD_START: begin
                wait_ph = PH_PRESS;
            end
            CMD_STOP: begin
                selects  = 3'b111;
                byte_cnt = 3'd0;
                fresh    = 1'b0;
                wait_ph  = PH_NONE;
            end
            default: begin
                if (!fresh) begin
                    r.fetch_status = 1'b1;
                end else begin
                    r.pressure    = {sample_mem[0][4:0], sample_mem[1], sample_mem[2],
                                     sample_mem[3][7:5]};
                    r.temperature = {sample_mem[4][6:0], sample_mem[5][7:3]};
                    r.battery     = {sample_mem[6][6:0], sample_mem[7][7:5]};
                    fresh         = 1'b0;
                end
            end
        endcase
        r.data_ready    = fresh;
        r.cs_pressure_n = selects[0];
        r.cs_temp_n     = selects[1];
        r.cs_batt_n     = selects[2];
        pending_q.push_back(r);
    endfunction

    function void flag_field(string name, logic [23:0] want, logic [23:0] got);
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
    endfunction

    function void check_result(t_out_word got);
        t_out_word want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got.data_ready !== want.data_ready)
            flag_field("data_ready", 24'(want.data_ready), 24'(got.data_ready));
        if (got.fetch_status !== want.fetch_status)
            flag_field("fetch_status", 24'(want.fetch_status), 24'(got.fetch_status));
        if (got.pressure !== want.pressure)
            flag_field("pressure", want.pressure, got.pressure);
        if (got.temperature !== want.temperature)
            flag_field("temperature", 24'(want.temperature), 24'(got.temperature));
        if (got.battery !== want.battery)
            flag_field("battery", 24'(want.battery), 24'(got.battery));
        if (got.cs_pressure_n !== want.cs_pressure_n)
            flag_field("cs_pressure_n", 24'(want.cs_pressure_n), 24'(got.cs_pressure_n));
        if (got.cs_temp_n !== want.cs_temp_n)
            flag_field("cs_temp_n", 24'(want.cs_temp_n), 24'(got.cs_temp_n));
        if (got.cs_batt_n !== want.cs_batt_n)
            flag_field("cs_batt_n", 24'(want.cs_batt_n), 24'(got.cs_batt_n));
        if (got.send_valid !== want.send_valid)
            flag_field("send_valid", 24'(want.send_valid), 24'(got.send_valid));
        if (got.send_byte !== want.send_byte)
            flag_field("send_byte", 24'(want.send_byte), 24'(got.send_byte));
    endfunction
endclass

module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n;

    adcseq_in_if  in_if ();
    adcseq_out_if out_if ();
    adcseq_cfg_if cfg_if ();

    three_adc_spi_readout_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    readout_scoreboard sb = new();

    int items_sent    = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    bit hold_output   = 1'b0;

    always #1 i_clk = ~i_clk;

    // Every handshake is observed at the rising edge. Register writes only
    // happen while the block is idle, so their order against words is moot.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_command(cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.data);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.data);
        end
    end

    // Result receiver. It stalls at the rate of the current phase, and on
    // request holds off for a long stretch so that both internal registers
    // fill up and the input side has to stall.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                out_if.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_output = 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // Offer one word, with random idle cycles in front, and wait until the
    // block takes it.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < in_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    function automatic t_in_word poll_word(bit busy, bit miso, bit bvalid, logic [7:0] rx);
        t_in_word w;
        w.cmd        = CMD_POLL;
        w.busy_level = busy;
        w.miso_level = miso;
        w.byte_valid = bvalid;
        w.rx_byte    = rx;
        return w;
    endfunction

    // Non-poll commands carry random pin fields, which the block ignores.
    function automatic t_in_word cmd_word(t_cmd c);
        t_in_word w;
        logic [12:0] raw;
        raw   = 13'($urandom_range(0, 8191));
        w     = raw;
        w.cmd = c;
        return w;
    endfunction

    function automatic logic [7:0] rand_rx();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bit coin(int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // One readout cycle with random content: usually a start, a wait for the pressure
    // conversion, then eight bytes with the end-of-conversion polls for the
    // temperature and battery groups, and mostly one or two fetches. Now and then a
    // stop breaks the cycle off.
    task automatic run_readout();
        if (coin(75))
            send_word(cmd_word(CMD_START));
        repeat ($urandom_range(0, 3))
            send_word(poll_word(1'b1, coin(30), 1'b0, rand_rx()));
        // Occasionally a byte arrives in the same poll that ends conversion.
        send_word(poll_word(1'b0, coin(30), coin(10), rand_rx()));
        for (int k = 0; k < SAMPLE_BYTES; k++) begin
            if (coin(4)) begin
                send_word(cmd_word(CMD_STOP));
                return;
            end
            repeat ($urandom_range(0, 2))
                send_word(poll_word(coin(50), coin(20), 1'b0, rand_rx()));
            if (k == 4 || k == 6) begin
                if (coin(25)) begin
                    send_word(poll_word(coin(50), 1'b1, 1'b1, rand_rx()));
                    continue;
                end
                send_word(poll_word(coin(50), 1'b1, 1'b0, rand_rx()));
            end
            send_word(poll_word(coin(50), coin(20), 1'b1, rand_rx()));
        end
        if (coin(85)) begin
            send_word(cmd_word(CMD_FETCH));
            if (coin(20))
                send_word(cmd_word(CMD_FETCH));
        end
    endtask

    task automatic random_part(input int target);
        int start_cnt;
        logic [12:0] raw;
        start_cnt = items_sent;
        while (items_sent - start_cnt < target) begin
            if (coin(70)) begin
                run_readout();
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    raw = 13'($urandom_range(0, 8191));
                    send_word(raw);
                end
            end
        end
    endtask

    // Stop offering words and wait until every expected result is back.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_osr(input logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_gap_pct    = 8;
        out_stall_pct = 86;

        // Directed words, run with the command byte at its reset value.
        send_word(cmd_word(CMD_FETCH));                  // nothing to fetch yet
        send_word(poll_word(1'b0, 1'b1, 1'b0, 8'h00));   // idle, pins ignored
        send_word(poll_word(1'b1, 1'b0, 1'b1, 8'hFF));   // byte while stopped
        send_word(cmd_word(CMD_STOP));
        send_word(cmd_word(CMD_START));
        send_word(poll_word(1'b1, 1'b0, 1'b0, 8'h00));   // still converting
        // Conversion ends and a byte continues a transfer in the same poll.
        send_word(poll_word(1'b0, 1'b0, 1'b1, 8'hFF));
        send_word(poll_word(1'b1, 1'b1, 1'b1, 8'h00));
        send_word(poll_word(1'b0, 1'b0, 1'b1, 8'hAA));
        send_word(poll_word(1'b1, 1'b0, 1'b1, 8'h55));   // pressure group done
        send_word(poll_word(1'b0, 1'b0, 1'b0, 8'h00));
        send_word(poll_word(1'b0, 1'b1, 1'b0, 8'h00));   // temperature ready
        send_word(poll_word(1'b0, 1'b0, 1'b1, 8'hFF));
        send_word(poll_word(1'b1, 1'b1, 1'b1, 8'h80));   // miso and sixth byte
        send_word(poll_word(1'b0, 1'b1, 1'b0, 8'h00));   // battery ready
        send_word(poll_word(1'b0, 1'b0, 1'b1, 8'h7F));
        send_word(poll_word(1'b0, 1'b0, 1'b1, 8'hFF));   // count wraps, set fresh
        send_word(cmd_word(CMD_FETCH));
        send_word(cmd_word(CMD_FETCH));                  // already taken
        send_word(cmd_word(CMD_START));
        send_word(poll_word(1'b0, 1'b0, 1'b0, 8'h00));   // sends command byte
        send_word(cmd_word(CMD_STOP));
        send_word(poll_word(1'b0, 1'b1, 1'b0, 8'hFF));
        send_word(cmd_word(CMD_START));
        send_word(cmd_word(CMD_FETCH));
        drain();

        write_osr(8'hFF);
        random_part(260);
        drain();

        in_gap_pct    = 86;
        out_stall_pct = 8;
        write_osr(8'h00);
        random_part(260);
        drain();

        // Full rate on both sides, starting with a long output hold-off.
        in_gap_pct    = 0;
        out_stall_pct = 0;
        write_osr(8'($urandom_range(1, 254)));
        hold_output = 1'b1;
        random_part(260);
        drain();

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

### filelist.f
rtl/adcseq_pkg.sv
rtl/adcseq_ifs.sv
rtl/three_adc_spi_readout_sequencer.sv
verif/testbench.sv
